// ===== hdl/lax_pkg.sv =====
// Shared constants and sizes for the Lax advection stencil block.
// Depends on nothing; imported by the top level.
`default_nettype none

package lax_pkg;

    // Tile limits and value format.
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int VALUE_W    = 18;
    localparam int LINE_DEPTH = MAX_COLS + 2;

    // Fixed field widths.
    localparam int IDX_W      = 10;
    localparam int CFG_SIZE_W = 11;
    localparam int WEIGHT_W   = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Position counters hold up to the padded size and at least an output index.
    localparam int CNT_W  = ($clog2(MAX_COLS + 3) > IDX_W) ? $clog2(MAX_COLS + 3) : IDX_W;
    localparam int RCNT_W = ($clog2(MAX_ROWS + 3) > IDX_W) ? $clog2(MAX_ROWS + 3) : IDX_W;
    localparam int LA_W   = $clog2(LINE_DEPTH);

    // Arithmetic widths: weight = offset + step * index, product = weight * difference.
    localparam int PM_W   = WEIGHT_W + ((CNT_W > RCNT_W) ? CNT_W : RCNT_W) + 1;
    localparam int WGT_W  = PM_W + 1;
    localparam int PROD_W = WGT_W + VALUE_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    // The neighbor sum is scaled by 2^14, the result rounded half up by 2^16.
    localparam int SUM_SHIFT = 14;
    localparam int RND_SHIFT = 16;
    localparam int RND_BIAS  = 1 << (RND_SHIFT - 1);
    localparam int RES_W     = ACC_W - RND_SHIFT;

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = VALUE_W + 2 * IDX_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_U_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_U_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V_STEP   = 3'd5;

endpackage

`default_nettype wire

// ===== hdl/lax_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// Read and write at the same address in one cycle return the old contents.
`default_nettype none

module lax_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1026
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/lax_advection_stencil_step.sv =====
// Top level of the Lax advection stencil: position tracking, line buffers,
// weight and stencil pipeline, output skid. Uses lax_pkg and lax_ram.
`default_nettype none

// The block takes one halo-padded tile in raster order, one cell per word, and
// returns one updated value for every interior cell as soon as the cell below
// it in the padded tile has arrived. It accepts one word per clock and keeps
// that rate as long as the output side takes words. Two padded rows are kept in
// line RAMs (the row above in two copies so that the center and the right
// neighbor are read in the same cycle); the RAMs need no clearing after reset.
// An output register and one skid word catch a result that the output side
// does not take; input stops while the skid word is held.
// Tile size and weights are written through the configuration port while idle.
module lax_advection_stencil_step
    import lax_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration writes.
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input cells.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cell_value, zero pad
    input  wire logic [0:0]             s_axis_tuser,   // tile_start
    // Updated cells.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // new_value, out_row, out_col, zero pad
    output logic                        m_axis_tlast    // tile_last
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic               last;
    } t_result;

    function automatic logic [CNT_W-1:0] eff_cols(input logic [CFG_SIZE_W-1:0] v);
        logic [CNT_W-1:0] s;
        if (v == '0) begin
            s = CNT_W'(1);
        end else if (int'(v) > MAX_COLS) begin
            s = CNT_W'(MAX_COLS);
        end else begin
            s = CNT_W'(v);
        end
        return s;
    endfunction

    function automatic logic [RCNT_W-1:0] eff_rows(input logic [CFG_SIZE_W-1:0] v);
        logic [RCNT_W-1:0] s;
        if (v == '0) begin
            s = RCNT_W'(1);
        end else if (int'(v) > MAX_ROWS) begin
            s = RCNT_W'(MAX_ROWS);
        end else begin
            s = RCNT_W'(v);
        end
        return s;
    endfunction

    // Configuration.
    logic        [CNT_W-1:0]    r_cols;
    logic        [RCNT_W-1:0]   r_rows;
    logic signed [WEIGHT_W-1:0] r_u_off, r_u_step, r_v_off, r_v_step;

    // Position of the next cell in the padded tile.
    logic [CNT_W-1:0]  r_col;
    logic [RCNT_W-1:0] r_row;

    // Stage one: line buffer reads in flight.
    logic                      r_s1_vld, r_s1_emit, r_s1_last, r_s1_byp;
    logic [LA_W-1:0]           r_s1_addr;
    logic [CNT_W-1:0]          r_s1_col;
    logic [RCNT_W-1:0]         r_s1_row;
    logic signed [VALUE_W-1:0] r_s1_up;
    logic signed [VALUE_W-1:0] r_held;

    // Stage two: sum, differences, weight slopes.
    logic                      r_s2_vld, r_s2_last;
    logic [CNT_W-1:0]          r_s2_col;
    logic [RCNT_W-1:0]         r_s2_row;
    logic signed [VALUE_W+1:0] r_s2_sum;
    logic signed [VALUE_W:0]   r_s2_du, r_s2_dh;
    logic signed [PM_W-1:0]    r_s2_pu, r_s2_pv;

    // Stage three: weights.
    logic                      r_s3_vld, r_s3_last;
    logic [CNT_W-1:0]          r_s3_col;
    logic [RCNT_W-1:0]         r_s3_row;
    logic signed [ACC_W-1:0]   r_s3_base;
    logic signed [VALUE_W:0]   r_s3_du, r_s3_dh;
    logic signed [WGT_W-1:0]   r_s3_wu, r_s3_wv;

    // Stage four: products.
    logic                      r_s4_vld, r_s4_last;
    logic [CNT_W-1:0]          r_s4_col;
    logic [RCNT_W-1:0]         r_s4_row;
    logic signed [ACC_W-1:0]   r_s4_base;
    logic signed [PROD_W-1:0]  r_s4_pu, r_s4_pv;

    // Stage five: accumulated value in Q.16 plus rounding bias.
    logic                      r_s5_vld, r_s5_last;
    logic [CNT_W-1:0]          r_s5_col;
    logic [RCNT_W-1:0]         r_s5_row;
    logic signed [ACC_W-1:0]   r_s5_acc;

    // Output register and skid word.
    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;

    logic                      w_adv, w_acc, w_start, w_emit, w_last, w_wrap;
    logic [CNT_W-1:0]          w_c0, w_c_inc, n_col;
    logic [RCNT_W-1:0]         w_r0, w_r_inc, n_row;
    logic [LA_W-1:0]           w_right_addr;
    logic signed [VALUE_W-1:0] w_x;
    logic [VALUE_W-1:0]        w_mid_q, w_right_q, w_down_q;
    logic signed [VALUE_W-1:0] w_mid, w_right, w_down;
    logic signed [VALUE_W+1:0] w_sum;
    logic signed [VALUE_W:0]   w_du, w_dh;
    logic signed [PM_W-1:0]    w_pu, w_pv;
    logic [RES_W-1:0]          w_res;
    logic                      w_ovf;
    t_result                   w_new;
    logic                      w_out_free;

    // The whole pipeline moves together; it halts only while the skid word is held.
    assign w_adv         = ~r_skid_vld;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid & w_adv;
    assign w_start       = s_axis_tuser[0];
    assign w_x           = s_axis_tdata[VALUE_W-1:0];

    // Stage zero: position of this cell and whether it completes a stencil.
    always_comb begin
        w_c0    = w_start ? '0 : r_col;
        w_r0    = w_start ? '0 : r_row;
        w_emit  = (w_r0 > RCNT_W'(1)) && (w_r0 <= r_rows + RCNT_W'(1)) &&
                  (w_c0 != '0) && (w_c0 <= r_cols);
        w_last  = (w_r0 == r_rows + RCNT_W'(1)) && (w_c0 == r_cols);
        w_c_inc = w_c0 + CNT_W'(1);
        w_r_inc = w_r0 + RCNT_W'(1);
        w_wrap  = (w_c_inc >= r_cols + CNT_W'(2));
        n_col   = w_wrap ? '0 : w_c_inc;
        if (!w_wrap) begin
            n_row = w_r0;
        end else if (w_r_inc >= r_rows + RCNT_W'(2)) begin
            n_row = '0;
        end else begin
            n_row = w_r_inc;
        end
        // The column past the last line entry never feeds a result.
        w_right_addr = (w_c0 == CNT_W'(LINE_DEPTH - 1)) ? '0 : w_c_inc[LA_W-1:0];
    end

    // Row above: two copies, read at this column and the next.
    lax_ram #(.WIDTH(VALUE_W), .DEPTH(LINE_DEPTH)) u_line1_mid (
        .i_clk     (i_clk),
        .i_we      (w_acc),
        .i_wr_addr (w_c0[LA_W-1:0]),
        .i_wr_data (w_x),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_c0[LA_W-1:0]),
        .o_rd_data (w_mid_q)
    );

    lax_ram #(.WIDTH(VALUE_W), .DEPTH(LINE_DEPTH)) u_line1_right (
        .i_clk     (i_clk),
        .i_we      (w_acc),
        .i_wr_addr (w_c0[LA_W-1:0]),
        .i_wr_data (w_x),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_right_addr),
        .o_rd_data (w_right_q)
    );

    // Row two back: takes the old row-above value once its read has reached stage one.
    lax_ram #(.WIDTH(VALUE_W), .DEPTH(LINE_DEPTH)) u_line2 (
        .i_clk     (i_clk),
        .i_we      (w_adv & r_s1_vld),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_mid),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_c0[LA_W-1:0]),
        .o_rd_data (w_down_q)
    );

    // Stage one: when the word ahead wrote the same column of the row two back
    // in the cycle this word read it, its value is taken from the held cell.
    always_comb begin
        w_mid   = w_mid_q;
        w_right = w_right_q;
        w_down  = r_s1_byp ? r_held : w_down_q;
        w_sum   = r_s1_up + w_down + r_held + w_right;
        w_du    = r_s1_up - w_down;
        w_dh    = w_right - r_held;
        w_pu    = r_u_step * $signed({1'b0, r_s1_col});
        w_pv    = r_v_step * $signed({1'b0, r_s1_row});
    end

    // Stage five to output: floor shift, then saturate.
    always_comb begin
        w_res = r_s5_acc[ACC_W-1:RND_SHIFT];
        w_ovf = ~((&w_res[RES_W-1:VALUE_W-1]) | ~(|w_res[RES_W-1:VALUE_W-1]));
        if (!w_ovf) begin
            w_new.value = w_res[VALUE_W-1:0];
        end else if (w_res[RES_W-1]) begin
            w_new.value = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            w_new.value = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        w_new.row  = r_s5_row[IDX_W-1:0];
        w_new.col  = r_s5_col[IDX_W-1:0];
        w_new.last = r_s5_last;
    end

    assign w_out_free = ~r_out_vld | m_axis_tready;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols     <= CNT_W'(MAX_COLS);
            r_rows     <= RCNT_W'(MAX_ROWS);
            r_u_off    <= '0;
            r_u_step   <= '0;
            r_v_off    <= '0;
            r_v_step   <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_s4_vld   <= 1'b0;
            r_s5_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLS:     r_cols   <= eff_cols(i_cfg_data[CFG_SIZE_W-1:0]);
                    CFG_ROWS:     r_rows   <= eff_rows(i_cfg_data[CFG_SIZE_W-1:0]);
                    CFG_U_OFFSET: r_u_off  <= i_cfg_data[WEIGHT_W-1:0];
                    CFG_U_STEP:   r_u_step <= i_cfg_data[WEIGHT_W-1:0];
                    CFG_V_OFFSET: r_v_off  <= i_cfg_data[WEIGHT_W-1:0];
                    CFG_V_STEP:   r_v_step <= i_cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_adv) begin
                r_s1_vld <= w_acc;
                r_s2_vld <= r_s1_vld & r_s1_emit;
                r_s3_vld <= r_s2_vld;
                r_s4_vld <= r_s3_vld;
                r_s5_vld <= r_s4_vld;
            end
            if (w_out_free) begin
                if (r_skid_vld) begin
                    r_skid_vld <= 1'b0;
                    r_out_vld  <= 1'b1;
                end else begin
                    r_out_vld <= w_adv & r_s5_vld;
                end
            end else if (w_adv && r_s5_vld) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_emit <= w_emit;
            r_s1_last <= w_last;
            r_s1_byp  <= r_s1_vld && (r_s1_addr == w_c0[LA_W-1:0]);
            r_s1_addr <= w_c0[LA_W-1:0];
            r_s1_col  <= w_c0 - CNT_W'(1);
            r_s1_row  <= w_r0 - RCNT_W'(2);
            r_s1_up   <= w_x;
            if (r_s1_vld) begin
                r_held <= w_mid;
            end

            r_s2_last <= r_s1_last;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_sum  <= w_sum;
            r_s2_du   <= w_du;
            r_s2_dh   <= w_dh;
            r_s2_pu   <= w_pu;
            r_s2_pv   <= w_pv;

            r_s3_last <= r_s2_last;
            r_s3_col  <= r_s2_col;
            r_s3_row  <= r_s2_row;
            r_s3_base <= (ACC_W'(r_s2_sum) <<< SUM_SHIFT) + ACC_W'(RND_BIAS);
            r_s3_du   <= r_s2_du;
            r_s3_dh   <= r_s2_dh;
            r_s3_wu   <= r_u_off + r_s2_pu;
            r_s3_wv   <= r_v_off + r_s2_pv;

            r_s4_last <= r_s3_last;
            r_s4_col  <= r_s3_col;
            r_s4_row  <= r_s3_row;
            r_s4_base <= r_s3_base;
            r_s4_pu   <= r_s3_wu * r_s3_du;
            r_s4_pv   <= r_s3_wv * r_s3_dh;

            r_s5_last <= r_s4_last;
            r_s5_col  <= r_s4_col;
            r_s5_row  <= r_s4_row;
            r_s5_acc  <= r_s4_base - r_s4_pu - r_s4_pv;
        end
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else begin
                r_out <= w_new;
            end
        end else if (w_adv && r_s5_vld) begin
            r_skid <= w_new;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.col, r_out.row, r_out.value});
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire
